// ===== rtl/core/rgbyc_pkg.sv =====
`default_nettype none
package rgbyc_pkg;

  localparam int MAX_DIMENSION = 4096;
  localparam int CNT_W         = $clog2(MAX_DIMENSION);
  localparam int SIZE_W        = 13;
  localparam int PIX_W         = 8;
  localparam int CFG_IDX_W     = 2;
  localparam int COEF_W        = 16;
  localparam int PROD_W        = PIX_W + COEF_W;
  localparam int SUM_W         = PROD_W + 1;
  localparam int FRAC_W        = 16;

  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W    = FIFO_PTR_W + 1;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);

  localparam logic [COEF_W-1:0] Y_R_COEF  = COEF_W'(19595);
  localparam logic [COEF_W-1:0] Y_G_COEF  = COEF_W'(38470);
  localparam logic [COEF_W-1:0] Y_B_COEF  = COEF_W'(7471);
  localparam logic [COEF_W-1:0] CB_R_COEF = COEF_W'(11056);
  localparam logic [COEF_W-1:0] CB_G_COEF = COEF_W'(21712);
  localparam logic [COEF_W-1:0] CB_B_COEF = COEF_W'(32768);
  localparam logic [COEF_W-1:0] CR_R_COEF = COEF_W'(32768);
  localparam logic [COEF_W-1:0] CR_G_COEF = COEF_W'(27440);
  localparam logic [COEF_W-1:0] CR_B_COEF = COEF_W'(5328);
  localparam logic [SUM_W-1:0]  HALF_RANGE = SUM_W'(8388608);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = CFG_IDX_W'(0),
    CFG_HEIGHT = CFG_IDX_W'(1)
  } cfg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             chroma;
    logic             last;
  } req_t;

  function automatic logic [CNT_W-1:0] last_idx(input logic [SIZE_W-1:0] reg_v);
    logic [SIZE_W-1:0] v;
    v = reg_v;
    if (v < SIZE_W'(2)) begin
      v = SIZE_W'(2);
    end else if (v > SIZE_W'(MAX_DIMENSION)) begin
      v = SIZE_W'(MAX_DIMENSION);
    end
    v[0] = 1'b0;
    v = v - SIZE_W'(1);
    return v[CNT_W-1:0];
  endfunction

  function automatic logic [PIX_W-1:0] sat8(input logic [SUM_W-1:0] s);
    if (|s[SUM_W-1:FRAC_W+PIX_W]) begin
      return {PIX_W{1'b1}};
    end
    return s[FRAC_W+PIX_W-1:FRAC_W];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rgbyc_fifo.sv =====
`default_nettype none
module rgbyc_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire rgbyc_pkg::req_t push_data,
  output logic               full,
  output logic               not_empty,
  input  wire logic          pop,
  output rgbyc_pkg::req_t    pop_data
);

  rgbyc_pkg::req_t                          mem_r [rgbyc_pkg::FIFO_DEPTH];
  logic [rgbyc_pkg::FIFO_PTR_W-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [rgbyc_pkg::FIFO_PTR_W-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [rgbyc_pkg::FIFO_CNT_W-1:0]         count_r, count_nxt;
  logic                                     do_push, do_pop;

  assign full      = (count_r == rgbyc_pkg::FIFO_CNT_W'(rgbyc_pkg::FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/rgbyc_front.sv =====
`default_nettype none
module rgbyc_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [rgbyc_pkg::PIX_W-1:0]       in_red_in,
  input  wire logic [rgbyc_pkg::PIX_W-1:0]       in_green_in,
  input  wire logic [rgbyc_pkg::PIX_W-1:0]       in_blue_in,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [rgbyc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rgbyc_pkg::SIZE_W-1:0]      cfg_data,
  input  wire logic                              q_full,
  output logic                                   q_push,
  output rgbyc_pkg::req_t                        q_data
);

  logic [rgbyc_pkg::SIZE_W-1:0] width_r, height_r;
  logic [rgbyc_pkg::CNT_W-1:0]  col_r, col_nxt;
  logic [rgbyc_pkg::CNT_W-1:0]  row_r, row_nxt;
  logic [rgbyc_pkg::CNT_W-1:0]  col_end, row_end;
  logic                         col_last, row_last, accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;

  assign col_end  = rgbyc_pkg::last_idx(width_r);
  assign row_end  = rgbyc_pkg::last_idx(height_r);
  assign col_last = (col_r >= col_end);
  assign row_last = (row_r >= row_end);

  assign q_push        = accept;
  assign q_data.red    = in_red_in;
  assign q_data.green  = in_green_in;
  assign q_data.blue   = in_blue_in;
  assign q_data.chroma = !col_r[0] && !row_r[0];
  assign q_data.last   = col_last && row_last;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_last) begin
        col_nxt = '0;
        row_nxt = row_last ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= rgbyc_pkg::WIDTH_RESET;
      height_r <= rgbyc_pkg::HEIGHT_RESET;
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (cfg_valid) begin
        if (cfg_index == rgbyc_pkg::CFG_WIDTH) begin
          width_r <= cfg_data;
        end else if (cfg_index == rgbyc_pkg::CFG_HEIGHT) begin
          height_r <= cfg_data;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/rgbyc_back.sv =====
`default_nettype none
module rgbyc_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_not_empty,
  output logic                              q_pop,
  input  wire rgbyc_pkg::req_t              q_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [rgbyc_pkg::PIX_W-1:0]       out_luma,
  output logic                              out_chroma_valid,
  output logic [rgbyc_pkg::PIX_W-1:0]       out_chroma_blue,
  output logic [rgbyc_pkg::PIX_W-1:0]       out_chroma_red,
  output logic                              out_frame_last
);

  localparam int PW = rgbyc_pkg::PROD_W;
  localparam int SW = rgbyc_pkg::SUM_W;

  // stage 1: products
  logic          s1_valid_r;
  logic          s1_chroma_r, s1_last_r;
  logic [PW-1:0] yr_r, yg_r, yb_r;
  logic [PW-1:0] cbr_r, cbg_r, cbb_r;
  logic [PW-1:0] crr_r, crg_r, crb_r;

  // stage 2: output register
  logic                          out_valid_r;
  logic [rgbyc_pkg::PIX_W-1:0]   luma_r, cb_r, cr_r;
  logic                          chroma_r, last_r;

  logic          out_adv, s1_take;
  logic [SW-1:0] y_sum, cb_sum, cr_sum;

  assign out_adv = !out_valid_r || !out_stall;
  assign s1_take = !s1_valid_r || out_adv;
  assign q_pop   = s1_take && q_not_empty;

  assign y_sum  = SW'(yr_r) + SW'(yg_r) + SW'(yb_r);
  assign cb_sum = rgbyc_pkg::HALF_RANGE + SW'(cbb_r) - SW'(cbr_r) - SW'(cbg_r);
  assign cr_sum = rgbyc_pkg::HALF_RANGE + SW'(crr_r) - SW'(crg_r) - SW'(crb_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_take) begin
        s1_valid_r <= q_not_empty;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_chroma_r <= q_data.chroma;
      s1_last_r   <= q_data.last;
      yr_r  <= PW'(q_data.red)   * PW'(rgbyc_pkg::Y_R_COEF);
      yg_r  <= PW'(q_data.green) * PW'(rgbyc_pkg::Y_G_COEF);
      yb_r  <= PW'(q_data.blue)  * PW'(rgbyc_pkg::Y_B_COEF);
      cbr_r <= PW'(q_data.red)   * PW'(rgbyc_pkg::CB_R_COEF);
      cbg_r <= PW'(q_data.green) * PW'(rgbyc_pkg::CB_G_COEF);
      cbb_r <= PW'(q_data.blue)  * PW'(rgbyc_pkg::CB_B_COEF);
      crr_r <= PW'(q_data.red)   * PW'(rgbyc_pkg::CR_R_COEF);
      crg_r <= PW'(q_data.green) * PW'(rgbyc_pkg::CR_G_COEF);
      crb_r <= PW'(q_data.blue)  * PW'(rgbyc_pkg::CR_B_COEF);
    end
    if (out_adv && s1_valid_r) begin
      luma_r   <= rgbyc_pkg::sat8(y_sum);
      cb_r     <= s1_chroma_r ? rgbyc_pkg::sat8(cb_sum) : '0;
      cr_r     <= s1_chroma_r ? rgbyc_pkg::sat8(cr_sum) : '0;
      chroma_r <= s1_chroma_r;
      last_r   <= s1_last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_luma         = luma_r;
  assign out_chroma_valid = chroma_r;
  assign out_chroma_blue  = cb_r;
  assign out_chroma_red   = cr_r;
  assign out_frame_last   = last_r;

endmodule
`default_nettype wire

// ===== rtl/core/rgb_to_ycbcr420_stream_top.sv =====
// RGB to YCbCr 4:2:0 converter, full-range BT.601, one pixel per request.
// Input channel (in_valid / in_stall): 8-bit R, G, B in raster order for a
// frame of cfg width x height (clamped to 2..4096, rounded down to even).
// Output channel (out_valid / out_stall): luma for every pixel; Cb and Cr with
// chroma_valid on even rows and even columns (zero elsewhere); frame_last on
// the final pixel of the frame.
// Config channel (cfg_valid / cfg_ready): index 0 width, 1 height; other
// indexes are ignored. cfg_ready is always high; write only while idle.
// Throughput: one pixel per clock while out_stall is low, set by the two-stage
// multiply/sum pipeline.
// A four-entry queue sits between the pixel counter front end and the
// arithmetic; in_stall rises only when that queue is full, so a receiver
// stall backs up through the pipeline and queue before the source is held.
// Reset (synchronous, rst_n low) empties the queue and pipeline, clears the
// column and row counters and restores 640 x 480.
`default_nettype none
module rgb_to_ycbcr420_stream_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [rgbyc_pkg::PIX_W-1:0]       in_red_in,
  input  wire logic [rgbyc_pkg::PIX_W-1:0]       in_green_in,
  input  wire logic [rgbyc_pkg::PIX_W-1:0]       in_blue_in,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [rgbyc_pkg::PIX_W-1:0]            out_luma,
  output logic                                   out_chroma_valid,
  output logic [rgbyc_pkg::PIX_W-1:0]            out_chroma_blue,
  output logic [rgbyc_pkg::PIX_W-1:0]            out_chroma_red,
  output logic                                   out_frame_last,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [rgbyc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rgbyc_pkg::SIZE_W-1:0]      cfg_data
);

  logic            q_full, q_push, q_not_empty, q_pop;
  rgbyc_pkg::req_t q_wdata, q_rdata;

  rgbyc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_red_in   (in_red_in),
    .in_green_in (in_green_in),
    .in_blue_in  (in_blue_in),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  rgbyc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .pop_data  (q_rdata)
  );

  rgbyc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_not_empty      (q_not_empty),
    .q_pop            (q_pop),
    .q_data           (q_rdata),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_luma         (out_luma),
    .out_chroma_valid (out_chroma_valid),
    .out_chroma_blue  (out_chroma_blue),
    .out_chroma_red   (out_chroma_red),
    .out_frame_last   (out_frame_last)
  );

endmodule
`default_nettype wire

// ===== tb/rgb_to_ycbcr420_stream_top_tb.sv =====
module rgb_to_ycbcr420_stream_top_tb;

  localparam int PIX_W         = rgbyc_pkg::PIX_W;
  localparam int CFG_IDX_W     = rgbyc_pkg::CFG_IDX_W;
  localparam int SIZE_W        = rgbyc_pkg::SIZE_W;
  localparam int CNT_W         = rgbyc_pkg::CNT_W;
  localparam int MAX_DIMENSION = rgbyc_pkg::MAX_DIMENSION;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD    = 64;
  localparam int DIR_ROWS     = 20;
  localparam int NUM_PHASES   = 10;
  localparam int PHASE_ITEMS  = 45;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);

  // frame sizes per phase: clamped, odd and extreme values included
  localparam int PHASE_W [NUM_PHASES] = '{2, 0, 3, 4, 4096, 2, 8191, 6, 4095, 640};
  localparam int PHASE_H [NUM_PHASES] = '{2, 1, 5, 6, 2, 4096, 8191, 2, 3, 480};

  typedef struct packed {
    logic [PIX_W-1:0] luma;
    logic             chroma_valid;
    logic [PIX_W-1:0] cb;
    logic [PIX_W-1:0] cr;
    logic             frame_last;
  } ycc_t;

  typedef struct packed {
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
    logic             typed;
    ycc_t             want;
  } dir_row_t;

  typedef enum logic [1:0] {SEG_FREE, SEG_SPOTTY, SEG_BLOCKED, SEG_HOLD} seg_kind_t;

  localparam ycc_t NO_YCC = '0;

  // raster order from reset, 640 wide: chroma on even columns of row 0
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{8'h00, 8'h00, 8'h00, 1'b1, '{8'd0,   1'b1, 8'd128, 8'd128, 1'b0}},
    '{8'hFF, 8'hFF, 8'hFF, 1'b1, '{8'd255, 1'b0, 8'd0,   8'd0,   1'b0}},
    '{8'hFF, 8'h00, 8'h00, 1'b1, '{8'd76,  1'b1, 8'd84,  8'd255, 1'b0}},
    '{8'h00, 8'hFF, 8'h00, 1'b1, '{8'd149, 1'b0, 8'd0,   8'd0,   1'b0}},
    '{8'h00, 8'h00, 8'hFF, 1'b1, '{8'd29,  1'b1, 8'd255, 8'd107, 1'b0}},
    '{8'h00, 8'h00, 8'h00, 1'b1, '{8'd0,   1'b0, 8'd0,   8'd0,   1'b0}},
    '{8'hFF, 8'hFF, 8'hFF, 1'b1, '{8'd255, 1'b1, 8'd128, 8'd128, 1'b0}},
    '{8'h01, 8'h01, 8'h01, 1'b0, NO_YCC},
    '{8'h00, 8'hFF, 8'hFF, 1'b0, NO_YCC},
    '{8'hFF, 8'h00, 8'hFF, 1'b0, NO_YCC},
    '{8'hFF, 8'hFF, 8'h00, 1'b0, NO_YCC},
    '{8'h00, 8'hFF, 8'h00, 1'b0, NO_YCC},
    '{8'h00, 8'hFF, 8'h00, 1'b0, NO_YCC},
    '{8'h55, 8'hAA, 8'h55, 1'b0, NO_YCC},
    '{8'hAA, 8'h55, 8'hAA, 1'b0, NO_YCC},
    '{8'h80, 8'h7F, 8'h01, 1'b0, NO_YCC},
    '{8'h01, 8'hFE, 8'h80, 1'b0, NO_YCC},
    '{8'hFF, 8'h00, 8'hFF, 1'b0, NO_YCC},
    '{8'h7F, 8'h80, 8'hFE, 1'b0, NO_YCC},
    '{8'hFE, 8'h01, 8'h7F, 1'b0, NO_YCC}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [PIX_W-1:0]     in_red_in;
  logic [PIX_W-1:0]     in_green_in;
  logic [PIX_W-1:0]     in_blue_in;
  logic                 out_valid;
  logic                 out_stall;
  logic [PIX_W-1:0]     out_luma;
  logic                 out_chroma_valid;
  logic [PIX_W-1:0]     out_chroma_blue;
  logic [PIX_W-1:0]     out_chroma_red;
  logic                 out_frame_last;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]    cfg_data;

  rgb_to_ycbcr420_stream_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_red_in        (in_red_in),
    .in_green_in      (in_green_in),
    .in_blue_in       (in_blue_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_luma         (out_luma),
    .out_chroma_valid (out_chroma_valid),
    .out_chroma_blue  (out_chroma_blue),
    .out_chroma_red   (out_chroma_red),
    .out_frame_last   (out_frame_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // predictor state
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;
  logic [CNT_W-1:0]  col_pos;
  logic [CNT_W-1:0]  row_pos;

  ycc_t      pixel_expected [$];
  int        err_cnt      = 0;
  int        pixels_sent  = 0;
  int        frames_seen  = 0;
  int        burst_left   = 0;
  int        cycle_cnt    = 0;
  int        holds_wanted = 0;
  int        holds_done   = 0;
  int        seg_left     = 0;
  seg_kind_t seg_kind     = SEG_FREE;

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [CNT_W-1:0] final_index(input logic [SIZE_W-1:0] sz);
    int unsigned v;
    v = sz;
    if (v < 2) v = 2;
    if (v > MAX_DIMENSION) v = MAX_DIMENSION;
    v = v & ~32'd1;
    return CNT_W'(v - 1);
  endfunction

  function automatic logic [PIX_W-1:0] clip8(input int q16);
    int v;
    if (q16 < 0) return '0;
    v = q16 >>> 16;
    return (v > 255) ? PIX_W'(255) : PIX_W'(v);
  endfunction

  // converts one pixel and advances the raster position
  function automatic ycc_t convert_pixel(input logic [PIX_W-1:0] r, g, b);
    ycc_t o;
    int   ri;
    int   gi;
    int   bi;
    logic end_col;
    logic end_row;
    ri = r;
    gi = g;
    bi = b;
    end_col = col_pos >= final_index(width_reg);
    end_row = row_pos >= final_index(height_reg);
    o.luma         = clip8(19595 * ri + 38470 * gi + 7471 * bi);
    o.chroma_valid = !col_pos[0] && !row_pos[0];
    o.cb = o.chroma_valid ? clip8(8388608 - 11056 * ri - 21712 * gi + 32768 * bi) : '0;
    o.cr = o.chroma_valid ? clip8(8388608 + 32768 * ri - 27440 * gi - 5328 * bi) : '0;
    o.frame_last = end_col && end_row;
    if (end_col) begin
      col_pos = '0;
      row_pos = end_row ? '0 : row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
    return o;
  endfunction

  function automatic logic [PIX_W-1:0] rand_level();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] r, g, b, input logic typed,
                            input ycc_t want);
    ycc_t calc;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_red_in   <= r;
    in_green_in <= g;
    in_blue_in  <= b;
    do @(posedge clk); while (in_stall);
    calc = convert_pixel(r, g, b);
    pixel_expected.insert(pixel_expected.size(), typed ? want : calc);
    pixels_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == rgbyc_pkg::CFG_WIDTH) width_reg = val;
    else if (idx == rgbyc_pkg::CFG_HEIGHT) height_reg = val;
  endtask

  task automatic program_size(input logic [SIZE_W-1:0] w, h);
    write_reg(rgbyc_pkg::CFG_WIDTH, w);
    write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, SIZE_W'($urandom));
    write_reg(rgbyc_pkg::CFG_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pixel_expected.size() != 0) @(posedge clk);
  endtask

  // receiver: free, spotty and blocked stretches, plus long hold-offs on request
  always @(posedge clk) begin
    if (seg_left != 0) begin
      seg_left <= seg_left - 1;
      case (seg_kind)
        SEG_FREE:    out_stall <= 1'b0;
        SEG_SPOTTY:  out_stall <= ($urandom_range(0, 2) == 0);
        default:     out_stall <= 1'b1;
      endcase
    end else if (holds_done < holds_wanted) begin
      holds_done <= holds_done + 1;
      seg_kind   <= SEG_HOLD;
      seg_left   <= LONG_HOLD;
      out_stall  <= 1'b1;
    end else begin
      seg_kind  <= seg_kind_t'($urandom_range(0, 2));
      seg_left  <= ($urandom_range(0, 2) == 2) ? $urandom_range(1, 4) : $urandom_range(4, 40);
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_out
    ycc_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_expected.size() == 0) begin
        $error("result with no request pending");
        err_cnt++;
      end else begin
        want = pixel_expected.pop_front();
        if (out_luma !== want.luma) begin
          $error("luma: expected %0d, got %0d", want.luma, out_luma);
          err_cnt++;
        end
        if (out_chroma_valid !== want.chroma_valid) begin
          $error("chroma_valid: expected %0d, got %0d", want.chroma_valid, out_chroma_valid);
          err_cnt++;
        end
        if (out_chroma_blue !== want.cb) begin
          $error("chroma_blue: expected %0d, got %0d", want.cb, out_chroma_blue);
          err_cnt++;
        end
        if (out_chroma_red !== want.cr) begin
          $error("chroma_red: expected %0d, got %0d", want.cr, out_chroma_red);
          err_cnt++;
        end
        if (out_frame_last !== want.frame_last) begin
          $error("frame_last: expected %0d, got %0d", want.frame_last, out_frame_last);
          err_cnt++;
        end
      end
      if (out_frame_last === 1'b1) frames_seen++;
    end
  end

  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_red_in   = '0;
    in_green_in = '0;
    in_blue_in  = '0;
    out_stall   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = rgbyc_pkg::CFG_WIDTH;
    cfg_data    = '0;
    width_reg   = rgbyc_pkg::WIDTH_RESET;
    height_reg  = rgbyc_pkg::HEIGHT_RESET;
    col_pos     = '0;
    row_pos     = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIR_TABLE[i])
      send_pixel(DIR_TABLE[i].r, DIR_TABLE[i].g, DIR_TABLE[i].b,
                 DIR_TABLE[i].typed, DIR_TABLE[i].want);
    drain_results();

    // size changes land mid-frame; the raster position carries over
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      program_size(SIZE_W'(PHASE_W[ph]), SIZE_W'(PHASE_H[ph]));
      if (ph == 3 || ph == 7) holds_wanted++;
      repeat (PHASE_ITEMS) send_pixel(rand_level(), rand_level(), rand_level(), 1'b0, NO_YCC);
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Converted %0d pixels over %0d frame sizes (clamped, odd, extreme), %0d frame ends",
             pixels_sent, NUM_PHASES + 1, frames_seen);
    $display("Sender bursts and gaps, receiver stalls and long hold-offs with input backpressure");
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
